### rtl/core/assert_macros.svh
// Assertion macros shared by the collision core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

### rtl/core/cpic_pkg.sv
// Types, constants and helpers for the circle pair collision core.
package cpic_pkg;

  localparam int unsigned RAD_W       = 64;
  localparam int unsigned ROOT_W      = 32;
  localparam int unsigned W_Q_W       = 25;
  localparam int unsigned N_Q_W       = 17;
  localparam int unsigned SQRT_STAGES = 16;
  localparam int unsigned DIV_STAGES  = 9;
  localparam int unsigned PADDR_W     = 4;

  localparam logic [31:0] MIN_DIST = 32'd7;
  localparam logic [17:0] ONE_Q16  = 18'd65536;
  localparam logic [24:0] W_HALF   = 25'd8388608;

  localparam logic [16:0] RESTITUTION_RST = 17'd39322;
  localparam logic [16:0] CORR_FRAC_RST   = 17'd52429;
  localparam logic [20:0] SLOP_RST        = 21'd655;

  typedef enum logic [1:0] {
    REG_RESTITUTION  = 2'd0,
    REG_CORR_FRAC    = 2'd1,
    REG_OVERLAP_SLOP = 2'd2
  } cpic_reg_e;

  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [31:0] first_vel_x;
    logic signed [31:0] first_vel_y;
    logic [30:0]        first_mass;
    logic [30:0]        first_radius;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [31:0] second_vel_x;
    logic signed [31:0] second_vel_y;
    logic [30:0]        second_mass;
    logic [30:0]        second_radius;
  } cpic_in_t;

  typedef struct packed {
    logic signed [31:0] new_first_pos_x;
    logic signed [31:0] new_first_pos_y;
    logic signed [31:0] new_first_vel_x;
    logic signed [31:0] new_first_vel_y;
    logic signed [31:0] new_second_pos_x;
    logic signed [31:0] new_second_pos_y;
    logic signed [31:0] new_second_vel_x;
    logic signed [31:0] new_second_vel_y;
    logic               overlapping;
    logic               resolved;
  } cpic_out_t;

  localparam logic signed [57:0] SAT_MAX = 58'sd2147483647;
  localparam logic signed [57:0] SAT_MIN = -58'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [57:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/cpic_isqrt.sv
// Pipelined digit-by-digit integer square root of a 64-bit radicand.
module cpic_isqrt #(
  parameter int unsigned Stages = cpic_pkg::SQRT_STAGES
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [cpic_pkg::RAD_W-1:0] rad_i,
  output logic [cpic_pkg::ROOT_W-1:0] root_o
);
  import cpic_pkg::*;

  localparam int unsigned Steps = ROOT_W;
  localparam int unsigned Bps   = (Steps + Stages - 1) / Stages;

  logic [RAD_W-1:0] v_q [Stages];
  logic [RAD_W-1:0] r_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [RAD_W-1:0] v_d, r_d;

    always_comb begin
      logic [RAD_W:0] bt, t;
      int j;
      if (s == 0) begin
        v_d = rad_i;
        r_d = '0;
      end else begin
        v_d = v_q[s-1];
        r_d = r_q[s-1];
      end
      for (int b = 0; b < Bps; b++) begin
        j = s * Bps + b;
        if (j < Steps) begin
          bt = (RAD_W+1)'(1) << (RAD_W - 2 - 2 * j);
          t  = {1'b0, r_d} + bt;
          if ({1'b0, v_d} >= t) begin
            v_d = v_d - t[RAD_W-1:0];
            r_d = (r_d >> 1) + bt[RAD_W-1:0];
          end else begin
            r_d = r_d >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[s] <= v_d;
        r_q[s] <= r_d;
      end
    end
  end

  assign root_o = r_q[Stages-1][ROOT_W-1:0];

endmodule

### rtl/core/cpic_div.sv
// Pipelined restoring divider for an unsigned quotient of known width.
module cpic_div #(
  parameter int unsigned NumW   = 48,
  parameter int unsigned DenW   = 32,
  parameter int unsigned QuoW   = cpic_pkg::N_Q_W,
  parameter int unsigned Stages = cpic_pkg::DIV_STAGES
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);
  import cpic_pkg::*;

  localparam int unsigned RemW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;
  localparam int unsigned Bps  = (QuoW + Stages - 1) / Stages;

  logic [RemW-1:0] rem_q [Stages];
  logic [DenW-1:0] den_q [Stages];
  logic [QuoW-1:0] quo_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [RemW-1:0] rem_d;
    logic [DenW-1:0] den_d;
    logic [QuoW-1:0] quo_d;

    always_comb begin
      logic [RemW-1:0] t;
      int j;
      if (s == 0) begin
        rem_d = RemW'(num_i);
        den_d = den_i;
        quo_d = '0;
      end else begin
        rem_d = rem_q[s-1];
        den_d = den_q[s-1];
        quo_d = quo_q[s-1];
      end
      for (int b = 0; b < Bps; b++) begin
        j = s * Bps + b;
        if (j < QuoW) begin
          t = RemW'(den_d) << (QuoW - 1 - j);
          if (rem_d >= t) begin
            rem_d = rem_d - t;
            quo_d[QuoW-1-j] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_d;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[Stages-1];

endmodule

### rtl/core/circle_pair_impulse_collision_core.sv
// Top level of the circle pair impulse collision core.
// Resolves one contact per transfer: takes a pair of circular bodies and
// returns both bodies after the restitution impulse and positional
// correction, or unchanged when they do not overlap or already separate.
// Fully pipelined: one pair enters per clock while the skid register below
// is empty, and the pipe stalls as a whole while that register is full.
// Latency is set by the square root pipeline (two root bits per stage) and
// the normal-vector divider (two quotient bits per stage); the mass-weight
// dividers run beside the square root. A one-entry skid register behind the
// output holds a result that the sink did not take.
// Configuration registers: restitution at 0x0, correction fraction at 0x4,
// overlap slop at 0x8; write only while the core is empty.
module circle_pair_impulse_collision_core #(
  parameter int unsigned SqrtStages = cpic_pkg::SQRT_STAGES,
  parameter int unsigned DivStages  = cpic_pkg::DIV_STAGES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  cpic_pkg::cpic_in_t           in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output cpic_pkg::cpic_out_t          out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpic_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cpic_pkg::*;

  localparam int unsigned BSum  = 3;
  localparam int unsigned BDist = BSum + SqrtStages + 1;
  localparam int unsigned BN    = BDist + DivStages + 1;
  localparam int unsigned BOut  = BN + 6;
  localparam int unsigned NB    = BOut + 1;

  typedef struct packed {
    cpic_in_t           pl;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
    logic [31:0]        rsum;
    logic [31:0]        msum;
    logic               mz;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic               pre;
    logic [63:0]        a2;
    logic [63:0]        b2;
    logic [63:0]        r2;
    logic [63:0]        s;
    logic               ovl;
    logic [31:0]        dlen;
    logic signed [33:0] olap;
    logic [24:0]        wa;
    logic [24:0]        wb;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic [32:0]        exc;
    logic signed [50:0] prx;
    logic signed [50:0] pry;
    logic [33:0]        c;
    logic signed [35:0] vn;
    logic               res;
    logic [33:0]        ca;
    logic [33:0]        cb;
    logic [37:0]        p;
    logic signed [52:0] cax;
    logic signed [52:0] cay;
    logic signed [52:0] cbx;
    logic signed [52:0] cby;
    logic [37:0]        ga;
    logic [37:0]        gb;
    logic signed [56:0] gax;
    logic signed [56:0] gay;
    logic signed [56:0] gbx;
    logic signed [56:0] gby;
    cpic_out_t          po;
  } cpic_sb_t;

  // configuration registers
  logic [16:0] rest_q, cfrac_q;
  logic [20:0] slop_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q  <= RESTITUTION_RST;
      cfrac_q <= CORR_FRAC_RST;
      slop_q  <= SLOP_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (cpic_reg_e'(paddr[3:2]))
        REG_RESTITUTION:  rest_q  <= pwdata[16:0];
        REG_CORR_FRAC:    cfrac_q <= pwdata[16:0];
        REG_OVERLAP_SLOP: slop_q  <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cpic_reg_e'(paddr[3:2]))
      REG_RESTITUTION:  prdata = {15'd0, rest_q};
      REG_CORR_FRAC:    prdata = {15'd0, cfrac_q};
      REG_OVERLAP_SLOP: prdata = {11'd0, slop_q};
      default:          prdata = '0;
    endcase
  end

  // pipeline control: whole pipe advances unless the skid register is full
  logic          en;
  logic [NB-1:0] vld_q;
  logic          sk_vld_q;
  cpic_out_t     sk_q;
  cpic_sb_t      sb_q [NB];
  cpic_sb_t      sb_d [NB];

  assign en         = !sk_vld_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NB-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NB; k++) sb_q[k] <= sb_d[k];
    end
  end

  // arithmetic units
  logic [ROOT_W-1:0] root;
  logic [W_Q_W-1:0]  wa_div, wb_div;
  logic [N_Q_W-1:0]  nxq, nyq;

  cpic_isqrt #(.Stages(SqrtStages)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sb_q[BSum].s),
    .root_o (root)
  );

  cpic_div #(.NumW(55), .DenW(32), .QuoW(W_Q_W), .Stages(SqrtStages)) u_div_wa (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({sb_q[BSum].pl.second_mass, 24'd0}),
    .den_i (sb_q[BSum].msum),
    .quo_o (wa_div)
  );

  cpic_div #(.NumW(55), .DenW(32), .QuoW(W_Q_W), .Stages(SqrtStages)) u_div_wb (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({sb_q[BSum].pl.first_mass, 24'd0}),
    .den_i (sb_q[BSum].msum),
    .quo_o (wb_div)
  );

  cpic_div #(.NumW(48), .DenW(32), .QuoW(N_Q_W), .Stages(DivStages)) u_div_nx (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({sb_q[BDist].adx, 16'd0}),
    .den_i (sb_q[BDist].dlen),
    .quo_o (nxq)
  );

  cpic_div #(.NumW(48), .DenW(32), .QuoW(N_Q_W), .Stages(DivStages)) u_div_ny (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({sb_q[BDist].ady, 16'd0}),
    .den_i (sb_q[BDist].dlen),
    .quo_o (nyq)
  );

  always_comb begin
    logic [64:0]        sum65;
    logic signed [32:0] sdx, sdy;
    logic signed [34:0] ex35;
    logic [49:0]        cfull;
    logic signed [51:0] vsum;
    logic [58:0]        caf, cbf;
    logic [17:0]        e18;
    logic [35:0]        nvn;
    logic [53:0]        pfull;
    logic [62:0]        gaf, gbf;
    cpic_sb_t           t;

    sb_d[0] = sb_q[0];
    for (int k = 1; k < NB; k++) sb_d[k] = sb_q[k-1];

    // differences and sums
    t      = sb_q[0];
    t.pl   = in_i;
    t.dx   = 33'(in_i.second_pos_x) - 33'(in_i.first_pos_x);
    t.dy   = 33'(in_i.second_pos_y) - 33'(in_i.first_pos_y);
    t.rvx  = 33'(in_i.second_vel_x) - 33'(in_i.first_vel_x);
    t.rvy  = 33'(in_i.second_vel_y) - 33'(in_i.first_vel_y);
    t.rsum = {1'b0, in_i.first_radius} + {1'b0, in_i.second_radius};
    t.msum = {1'b0, in_i.first_mass} + {1'b0, in_i.second_mass};
    t.mz   = (in_i.first_mass == '0) && (in_i.second_mass == '0);
    sb_d[0] = t;

    // magnitudes and bounding-box precheck
    t     = sb_q[0];
    sdx   = t.dx[32] ? -t.dx : t.dx;
    sdy   = t.dy[32] ? -t.dy : t.dy;
    t.adx = sdx[31:0];
    t.ady = sdy[31:0];
    t.pre = (t.rsum != '0) && (t.adx < t.rsum) && (t.ady < t.rsum);
    sb_d[1] = t;

    // squares
    t    = sb_q[1];
    t.a2 = 64'(t.adx) * 64'(t.adx);
    t.b2 = 64'(t.ady) * 64'(t.ady);
    t.r2 = 64'(t.rsum) * 64'(t.rsum);
    sb_d[2] = t;

    // squared distance; a carry out means no overlap
    t     = sb_q[2];
    sum65 = {1'b0, t.a2} + {1'b0, t.b2};
    t.s   = sum65[63:0];
    t.ovl = t.pre && !sum65[64] && (sum65[63:0] < t.r2);
    sb_d[BSum] = t;

    // floor distance, overlap depth, mass weights
    t      = sb_q[BDist-1];
    t.dlen = (root < MIN_DIST) ? MIN_DIST : root;
    t.olap = $signed({2'b00, t.rsum}) - $signed({2'b00, t.dlen});
    t.wa   = t.mz ? W_HALF : wa_div;
    t.wb   = t.mz ? W_HALF : wb_div;
    sb_d[BDist] = t;

    // signed normal and excess overlap
    t    = sb_q[BN-1];
    t.nx = t.dx[32] ? -$signed({1'b0, nxq}) : $signed({1'b0, nxq});
    t.ny = t.dy[32] ? -$signed({1'b0, nyq}) : $signed({1'b0, nyq});
    ex35 = 35'(t.olap) - $signed({14'd0, slop_q});
    t.exc = ex35[34] ? '0 : ex35[32:0];
    sb_d[BN] = t;

    // normal velocity products, correction magnitude
    t     = sb_q[BN];
    t.prx = 51'(t.rvx) * 51'(t.nx);
    t.pry = 51'(t.rvy) * 51'(t.ny);
    cfull = 50'(t.exc) * 50'(cfrac_q);
    t.c   = cfull[49:16];
    sb_d[BN+1] = t;

    // normal velocity, resolve decision, weighted correction
    t     = sb_q[BN+1];
    vsum  = 52'(t.prx) + 52'(t.pry);
    t.vn  = vsum[51:16];
    t.res = t.ovl && (t.vn[35] || (t.vn == '0));
    caf   = 59'(t.c) * 59'(t.wa);
    cbf   = 59'(t.c) * 59'(t.wb);
    t.ca  = caf[57:24];
    t.cb  = cbf[57:24];
    sb_d[BN+2] = t;

    // impulse magnitude, position shifts
    t     = sb_q[BN+2];
    e18   = ONE_Q16 + {1'b0, rest_q};
    nvn   = -t.vn;
    pfull = 54'(e18) * 54'(nvn);
    t.p   = pfull[53:16];
    t.cax = $signed({1'b0, t.ca}) * 53'(t.nx);
    t.cay = $signed({1'b0, t.ca}) * 53'(t.ny);
    t.cbx = $signed({1'b0, t.cb}) * 53'(t.nx);
    t.cby = $signed({1'b0, t.cb}) * 53'(t.ny);
    sb_d[BN+3] = t;

    // per-body impulse, corrected positions
    t    = sb_q[BN+3];
    gaf  = 63'(t.p) * 63'(t.wa);
    gbf  = 63'(t.p) * 63'(t.wb);
    t.ga = gaf[61:24];
    t.gb = gbf[61:24];
    t.po.overlapping = t.ovl;
    t.po.resolved    = t.res;
    if (t.res) begin
      t.po.new_first_pos_x  = sat32(58'($signed(t.pl.first_pos_x)) - 58'(t.cax >>> 16));
      t.po.new_first_pos_y  = sat32(58'($signed(t.pl.first_pos_y)) - 58'(t.cay >>> 16));
      t.po.new_second_pos_x = sat32(58'($signed(t.pl.second_pos_x)) + 58'(t.cbx >>> 16));
      t.po.new_second_pos_y = sat32(58'($signed(t.pl.second_pos_y)) + 58'(t.cby >>> 16));
    end else begin
      t.po.new_first_pos_x  = t.pl.first_pos_x;
      t.po.new_first_pos_y  = t.pl.first_pos_y;
      t.po.new_second_pos_x = t.pl.second_pos_x;
      t.po.new_second_pos_y = t.pl.second_pos_y;
    end
    sb_d[BN+4] = t;

    // velocity change products
    t     = sb_q[BN+4];
    t.gax = $signed({1'b0, t.ga}) * 57'(t.nx);
    t.gay = $signed({1'b0, t.ga}) * 57'(t.ny);
    t.gbx = $signed({1'b0, t.gb}) * 57'(t.nx);
    t.gby = $signed({1'b0, t.gb}) * 57'(t.ny);
    sb_d[BN+5] = t;

    // new velocities
    t = sb_q[BN+5];
    if (t.res) begin
      t.po.new_first_vel_x  = sat32(58'($signed(t.pl.first_vel_x)) - 58'(t.gax >>> 16));
      t.po.new_first_vel_y  = sat32(58'($signed(t.pl.first_vel_y)) - 58'(t.gay >>> 16));
      t.po.new_second_vel_x = sat32(58'($signed(t.pl.second_vel_x)) + 58'(t.gbx >>> 16));
      t.po.new_second_vel_y = sat32(58'($signed(t.pl.second_vel_y)) + 58'(t.gby >>> 16));
    end else begin
      t.po.new_first_vel_x  = t.pl.first_vel_x;
      t.po.new_first_vel_y  = t.pl.first_vel_y;
      t.po.new_second_vel_x = t.pl.second_vel_x;
      t.po.new_second_vel_y = t.pl.second_vel_y;
    end
    sb_d[BOut] = t;
  end

  // skid register: hold a result the sink did not take
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_vld_q <= 1'b0;
    end else if (sk_vld_q) begin
      if (out_ready_i) sk_vld_q <= 1'b0;
    end else if (vld_q[NB-1] && !out_ready_i) begin
      sk_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!sk_vld_q) sk_q <= sb_q[NB-1].po;
  end

  assign out_valid_o = sk_vld_q || vld_q[NB-1];
  assign out_o       = sk_vld_q ? sk_q : sb_q[NB-1].po;

`include "assert_macros.svh"

  `ASSERT_NEVER(a_res_needs_ovl, out_valid_o && out_o.resolved && !out_o.overlapping, "resolved without overlap")
  `ASSERT_RST(a_skid_fill, $rose(sk_vld_q) |-> $past(vld_q[NB-1] && !out_ready_i), "skid filled without stall")
  `ASSERT_RST(a_pipe_hold, sk_vld_q |=> $stable(vld_q), "pipeline moved while skid full")
  `ASSERT_RST(a_pass_pos, (vld_q[NB-1] && !sb_q[NB-1].po.resolved) |-> (sb_q[NB-1].po.new_first_pos_x == sb_q[NB-1].pl.first_pos_x), "unresolved pair altered")

endmodule

### sim/cpic_contact_checker.sv
// Checker for the circle pair collision core: predicts each contact and compares results.
`timescale 1ns / 1ps

module cpic_contact_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  cpic_pkg::cpic_in_t           in_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  cpic_pkg::cpic_out_t          out_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpic_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         pready,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           overlap_count_o,
  output int                           resolved_count_o
);
  import cpic_pkg::*;

  typedef logic signed [127:0] wide_t;

  wide_t     restitution_q;
  wide_t     corr_frac_q;
  wide_t     slop_q;
  cpic_out_t expected_contacts[$];

  function automatic wide_t root_floor(input logic [63:0] v);
    logic [31:0] r;
    logic [31:0] trial;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (32'd1 << i);
      if ({32'd0, trial} * {32'd0, trial} <= v) begin
        r = trial;
      end
    end
    return wide_t'({96'd0, r});
  endfunction

  function automatic logic signed [31:0] clamp32(input wide_t x);
    if (x > 128'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -128'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic cpic_out_t resolve_contact(input cpic_in_t a);
    cpic_out_t o;
    wide_t pax, pay, vax, vay, pbx, pby, vbx, vby;
    wide_t m1, m2, r1, r2, dx, dy, adx, ady, rsum, sq;
    wide_t dlen, overlap, nx, ny, vn, msum, wa, wb, p, ga, gb, exc, c, ca, cb;
    logic ovl, res;
    pax = $signed(a.first_pos_x);
    pay = $signed(a.first_pos_y);
    vax = $signed(a.first_vel_x);
    vay = $signed(a.first_vel_y);
    pbx = $signed(a.second_pos_x);
    pby = $signed(a.second_pos_y);
    vbx = $signed(a.second_vel_x);
    vby = $signed(a.second_vel_y);
    m1 = {97'd0, a.first_mass};
    m2 = {97'd0, a.second_mass};
    r1 = {97'd0, a.first_radius};
    r2 = {97'd0, a.second_radius};
    dx = pbx - pax;
    dy = pby - pay;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    rsum = r1 + r2;
    sq = adx * adx + ady * ady;
    ovl = (rsum > 0) && (adx < rsum) && (ady < rsum) && (sq < rsum * rsum);
    res = 1'b0;
    if (ovl) begin
      dlen = root_floor(sq[63:0]);
      if (dlen < 7) dlen = 7;
      overlap = rsum - dlen;
      nx = (dx * 65536) / dlen;
      ny = (dy * 65536) / dlen;
      vn = ((vbx - vax) * nx + (vby - vay) * ny) >>> 16;
      if (vn <= 0) begin
        res = 1'b1;
        msum = m1 + m2;
        if (msum == 0) begin
          wa = 128'sd8388608;
          wb = wa;
        end else begin
          wa = (m2 <<< 24) / msum;
          wb = (m1 <<< 24) / msum;
        end
        p = ((65536 + restitution_q) * (-vn)) >>> 16;
        ga = (p * wa) >>> 24;
        gb = (p * wb) >>> 24;
        vax = vax - ((ga * nx) >>> 16);
        vay = vay - ((ga * ny) >>> 16);
        vbx = vbx + ((gb * nx) >>> 16);
        vby = vby + ((gb * ny) >>> 16);
        exc = overlap - slop_q;
        if (exc < 0) exc = 0;
        c = (exc * corr_frac_q) >>> 16;
        ca = (c * wa) >>> 24;
        cb = (c * wb) >>> 24;
        pax = pax - ((ca * nx) >>> 16);
        pay = pay - ((ca * ny) >>> 16);
        pbx = pbx + ((cb * nx) >>> 16);
        pby = pby + ((cb * ny) >>> 16);
      end
    end
    o.new_first_pos_x  = clamp32(pax);
    o.new_first_pos_y  = clamp32(pay);
    o.new_first_vel_x  = clamp32(vax);
    o.new_first_vel_y  = clamp32(vay);
    o.new_second_pos_x = clamp32(pbx);
    o.new_second_pos_y = clamp32(pby);
    o.new_second_vel_x = clamp32(vbx);
    o.new_second_vel_y = clamp32(vby);
    o.overlapping      = ovl;
    o.resolved         = res;
    return o;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, field, got,
             want);
    fail_count_o++;
  endtask

  task automatic compare_contact(input cpic_out_t got, input cpic_out_t want);
    string       names[10];
    logic [31:0] g[10];
    logic [31:0] w[10];
    names = '{"new_first_pos_x", "new_first_pos_y", "new_first_vel_x", "new_first_vel_y",
              "new_second_pos_x", "new_second_pos_y", "new_second_vel_x",
              "new_second_vel_y", "overlapping", "resolved"};
    g = '{got.new_first_pos_x, got.new_first_pos_y, got.new_first_vel_x,
          got.new_first_vel_y, got.new_second_pos_x, got.new_second_pos_y,
          got.new_second_vel_x, got.new_second_vel_y, {31'd0, got.overlapping},
          {31'd0, got.resolved}};
    w = '{want.new_first_pos_x, want.new_first_pos_y, want.new_first_vel_x,
          want.new_first_vel_y, want.new_second_pos_x, want.new_second_pos_y,
          want.new_second_vel_x, want.new_second_vel_y, {31'd0, want.overlapping},
          {31'd0, want.resolved}};
    for (int i = 0; i < 10; i++) begin
      if (g[i] !== w[i]) report_mismatch(names[i], g[i], w[i]);
    end
  endtask

  assign pending_o = expected_contacts.size();

  always @(posedge clk_i or negedge rst_ni) begin
    cpic_out_t want;
    if (!rst_ni) begin
      restitution_q    <= wide_t'(RESTITUTION_RST);
      corr_frac_q      <= wide_t'(CORR_FRAC_RST);
      slop_q           <= wide_t'(SLOP_RST);
      fail_count_o     = 0;
      overlap_count_o  <= 0;
      resolved_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cpic_reg_e'(paddr[3:2]))
          REG_RESTITUTION:  restitution_q <= wide_t'(pwdata[16:0]);
          REG_CORR_FRAC:    corr_frac_q   <= wide_t'(pwdata[16:0]);
          REG_OVERLAP_SLOP: slop_q        <= wide_t'(pwdata[20:0]);
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_contacts.push_back(resolve_contact(in_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_contacts.size() == 0) begin
          $display("[%0t] result transfer with nothing expected", $realtime);
          fail_count_o++;
        end else begin
          want = expected_contacts.pop_front();
          compare_contact(out_i, want);
          overlap_count_o  <= overlap_count_o + int'(want.overlapping);
          resolved_count_o <= resolved_count_o + int'(want.resolved);
        end
      end
    end
  end

endmodule

### sim/tb_circle_pair_impulse_collision_core.sv
// Testbench top for the circle pair collision core: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb_circle_pair_impulse_collision_core;
  import cpic_pkg::*;

  localparam int NumPhases  = 6;
  localparam int PhaseItems = 275;
  localparam int IdleLimit  = 5000;
  localparam int HoldCycles = 300;
  localparam int DrainWait  = 60;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  cpic_in_t           in_data;
  logic               out_valid;
  logic               out_ready;
  cpic_out_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count, pending, overlap_count, resolved_count;
  int sender_idle_pct, recv_stall_pct;
  int items_sent;
  bit hold_request;

  circle_pair_impulse_collision_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  cpic_contact_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_i            (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_i           (out_data),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .overlap_count_o (overlap_count),
    .resolved_count_o(resolved_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic cpic_in_t make_pair(
      input logic [31:0] ax, ay, avx, avy, input logic [30:0] am, ar,
      input logic [31:0] bx, by, bvx, bvy, input logic [30:0] bm, br);
    cpic_in_t p;
    p.first_pos_x = ax;   p.first_pos_y = ay;
    p.first_vel_x = avx;  p.first_vel_y = avy;
    p.first_mass = am;    p.first_radius = ar;
    p.second_pos_x = bx;  p.second_pos_y = by;
    p.second_vel_x = bvx; p.second_vel_y = bvy;
    p.second_mass = bm;   p.second_radius = br;
    return p;
  endfunction

  function automatic logic [31:0] scaled_rand(input int bits);
    logic [31:0] v;
    v = $urandom & ((bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1));
    return $urandom_range(1) ? -v : v;
  endfunction

  // Mostly pairs placed within reach of each other; a share of raw noise.
  function automatic cpic_in_t random_pair();
    cpic_in_t p;
    int sc, vs;
    logic [30:0] r1, r2;
    logic [31:0] dx, dy, bx, by;
    if ($urandom_range(99) < 15) begin
      p = make_pair($urandom, $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom),
                    $urandom, $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom));
      return p;
    end
    sc = $urandom_range(4, 29);
    vs = $urandom_range(4, 31);
    r1 = 31'($urandom) & ((31'd1 << sc) - 1);
    r2 = 31'($urandom) & ((31'd1 << sc) - 1);
    dx = scaled_rand(sc);
    dy = scaled_rand(sc);
    if ($urandom_range(9) == 0) begin
      dx = 32'($urandom_range(3));
      dy = 32'($urandom_range(3));
    end
    bx = $urandom;
    by = $urandom;
    if ($urandom_range(3) == 0) begin
      bx = scaled_rand(20);
      by = scaled_rand(20);
    end
    p.first_pos_x   = bx;
    p.first_pos_y   = by;
    p.second_pos_x  = bx + dx;
    p.second_pos_y  = by + dy;
    p.first_vel_x   = scaled_rand(vs);
    p.first_vel_y   = scaled_rand(vs);
    p.second_vel_x  = scaled_rand(vs);
    p.second_vel_y  = scaled_rand(vs);
    p.first_mass    = ($urandom_range(19) == 0) ? 31'd0 : 31'($urandom) >> $urandom_range(30);
    p.second_mass   = ($urandom_range(19) == 0) ? 31'd0 : 31'($urandom) >> $urandom_range(30);
    p.first_radius  = r1;
    p.second_radius = r2;
    return p;
  endfunction

  task automatic send_pair(input cpic_in_t pair);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= pair;
    do @(posedge clk_i); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  task automatic write_reg(input cpic_reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        @(posedge clk_i);
      end
    end
  end

  // Stop when no transfer moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
        $display("[%0t] no transfer for %0d cycles", $realtime, IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    cpic_in_t directed[$];
    int idle_modes[4][2];
    logic [31:0] cfg[NumPhases][3];
    idle_modes = '{'{0, 0}, '{83, 0}, '{0, 83}, '{7, 7}};
    cfg = '{'{32'd39322, 32'd52429, 32'd655},
            '{32'd0, 32'd0, 32'd0},
            '{32'd65536, 32'd65536, 32'd1048576},
            '{32'h1FFFF, 32'h1FFFF, 32'h1FFFFF},
            '{32'hFFFF_FFFF, 32'd12345, 32'd70000},
            '{32'd39322, 32'd52429, 32'd655}};
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b0;
    items_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // far apart, zero radius sum, coincident centers, separating, approaching
    directed.push_back(make_pair(0, 0, 0, 0, 65536, 65536, 32'h0010_0000, 0, 0, 0, 65536,
                                 65536));
    directed.push_back(make_pair(5, 5, 1, 1, 65536, 0, 5, 5, 0, 0, 65536, 0));
    directed.push_back(make_pair(100, 100, 65536, 0, 65536, 65536, 100, 100, 0, 0, 65536,
                                 65536));
    directed.push_back(make_pair(0, 0, -65536, 0, 65536, 65536, 65536, 0, 65536, 0, 65536,
                                 65536));
    directed.push_back(make_pair(0, 0, 65536, 0, 65536, 65536, 65536, 0, -65536, 0, 65536,
                                 65536));
    directed.push_back(make_pair(0, 0, 65536, 32768, 0, 65536, 65536, 65536, -65536, 0, 0,
                                 65536));
    directed.push_back(make_pair(0, 0, 65536, 0, 0, 65536, 65536, 0, -65536, 0, 65536,
                                 65536));
    directed.push_back(make_pair(0, 0, 65536, 0, 65536, 65536, 65536, 0, -65536, 0, 0,
                                 65536));
    // radius sum under the distance floor
    directed.push_back(make_pair(0, 0, 9, 0, 65536, 2, 1, 0, 0, 0, 65536, 2));
    directed.push_back(make_pair(0, 0, 0, 0, 65536, 3, 0, 0, 0, 0, 65536, 2));
    // extremes and saturation
    directed.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_1000, 32'h8000_1000,
                                 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    directed.push_back(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                 1, 31'h7FFF_FFFF, 32'h7FFF_0000, 32'h7FFF_0000,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                                 31'h7FFF_FFFF));
    directed.push_back(make_pair(32'h7FFF_FFFF, 0, 0, 0, 1, 31'h7FFF_FFFF, 32'h8000_0000, 0,
                                 0, 0, 1, 31'h7FFF_FFFF));
    directed.push_back(make_pair(0, 0, 32'h4000_0000, 0, 31'h7FFF_FFFF, 31'h0100_0000,
                                 32'h0000_1000, 0, 32'hC000_0000, 0, 1, 31'h0100_0000));
    directed.push_back(make_pair(0, 0, 0, 0, 65536, 65536, 0, 131071, 0, -1, 65536, 65536));
    directed.push_back(make_pair(0, 0, 0, 0, 65536, 65536, 0, 131072, 0, -1, 65536, 65536));
    directed.push_back('0);
    directed.push_back('1);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(REG_RESTITUTION, cfg[ph][0]);
        write_reg(REG_CORR_FRAC, cfg[ph][1]);
        write_reg(REG_OVERLAP_SLOP, cfg[ph][2]);
      end
      sender_idle_pct = idle_modes[ph % 4][0];
      recv_stall_pct  = idle_modes[ph % 4][1];
      if (ph == 4) begin
        sender_idle_pct = 83;
        recv_stall_pct  = 83;
      end
      if (ph == 0) begin
        foreach (directed[i]) send_pair(directed[i]);
        hold_request = 1'b1;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        send_pair(random_pair());
      end
    end
    drain();

    $display("Sent %0d pairs over %0d register settings and several idle patterns;",
             items_sent, NumPhases);
    $display("%0d results overlapped, %0d of them resolved.", overlap_count,
             resolved_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
